// ===== rtl/djs_pkg.sv =====
// shared types and constants for the deadline job sequencer
// no dependencies
package djs_pkg;

	localparam int MAX_JOBS_DEF = 256;
	localparam int JOB_W = 33;
	localparam int DONE_W = 13;
	localparam logic [8:0] DONE_MAX = 9'h1FF;
	localparam logic [23:0] SUM_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [15:0] deadline;
		logic [15:0] profit;
		logic        last_job;
	} in_t;

	typedef struct packed {
		logic [8:0]  jobs_done;
		logic [23:0] total_profit;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEL,
		ST_MARK,
		ST_PROBE_RD,
		ST_PROBE_EV,
		ST_NEXT,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/djs_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module djs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/deadline_job_sequencer.sv =====
// greedy job sequencing with deadlines over a job ram and a slot ram
// depends on djs_pkg and djs_ram
// after the last beat the slot map is swept clear, then each job gets a select scan, a mark,
// slot probes from min(deadline, n) down to slot 1 and an advance; n = jobs in the set
// one set at a time; the next set is taken from the cycle after the result beat
// arst_n clears control state; ram contents are not reset, the slot map is
// swept clear at the start of every set
module deadline_job_sequencer #(
	parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  djs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output djs_pkg::out_t out_data
);

	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_JOBS);

	djs_pkg::state_t state_q, state_d;

	logic [CW-1:0] fill_q, n_q, cnt_q, round_q, slot_q;
	logic [djs_pkg::DONE_W-1:0] done_q;
	logic [23:0] sum_q;
	logic        found_q;
	logic [AW-1:0] best_idx_q;
	logic [15:0] best_d_q, best_p_q;

	logic              job_we;
	logic [AW-1:0]     job_waddr;
	logic [djs_pkg::JOB_W-1:0] job_wdata, job_rdata;
	logic              slot_we, slot_wdata;
	logic [AW-1:0]     slot_waddr, slot_addr;
	logic [0:0]        slot_rdata;

	logic          in_acc, take;
	logic [CW-1:0] s_min;
	logic [24:0]   sum_add;
	logic [CW-1:0] slot_m1;

	assign in_ready  = (state_q == djs_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (state_q == djs_pkg::ST_OUT);
	assign out_data.jobs_done = (done_q > djs_pkg::DONE_W'(djs_pkg::DONE_MAX))
		? djs_pkg::DONE_MAX : done_q[8:0];
	assign out_data.total_profit = sum_q;

	assign take = (state_q == djs_pkg::ST_SEL) && (cnt_q != '0) && !job_rdata[32]
		&& (!found_q || (job_rdata[15:0] > best_p_q));
	assign s_min = ({1'b0, best_d_q} > 17'(n_q)) ? n_q : CW'(best_d_q);
	assign sum_add = {1'b0, sum_q} + {9'b0, best_p_q};
	assign slot_m1 = slot_q - 1'b1;
	assign slot_addr = slot_m1[AW-1:0];

	assign job_we    = (in_acc && (fill_q != MAX_C)) || (state_q == djs_pkg::ST_MARK);
	assign job_waddr = (state_q == djs_pkg::ST_IDLE) ? fill_q[AW-1:0] : best_idx_q;
	assign job_wdata = (state_q == djs_pkg::ST_IDLE)
		? {1'b0, in_data.deadline, in_data.profit} : {1'b1, best_d_q, best_p_q};

	assign slot_we = (state_q == djs_pkg::ST_CLEAR)
		|| ((state_q == djs_pkg::ST_PROBE_EV) && !slot_rdata[0]);
	assign slot_waddr = (state_q == djs_pkg::ST_CLEAR) ? cnt_q[AW-1:0] : slot_addr;
	assign slot_wdata = (state_q == djs_pkg::ST_PROBE_EV);

	djs_ram #(.WIDTH(djs_pkg::JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
		.clk   (clk),
		.we    (job_we),
		.waddr (job_waddr),
		.wdata (job_wdata),
		.raddr (cnt_q[AW-1:0]),
		.rdata (job_rdata)
	);

	djs_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_addr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= djs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			djs_pkg::ST_IDLE: begin
				if (in_acc && in_data.last_job) begin
					state_d = djs_pkg::ST_CLEAR;
				end
			end
			djs_pkg::ST_CLEAR: begin
				if (cnt_q == n_q - 1'b1) begin
					state_d = djs_pkg::ST_SEL;
				end
			end
			djs_pkg::ST_SEL: begin
				if (cnt_q == n_q) begin
					state_d = djs_pkg::ST_MARK;
				end
			end
			djs_pkg::ST_MARK: begin
				state_d = (s_min == '0) ? djs_pkg::ST_NEXT : djs_pkg::ST_PROBE_RD;
			end
			djs_pkg::ST_PROBE_RD: begin
				state_d = djs_pkg::ST_PROBE_EV;
			end
			djs_pkg::ST_PROBE_EV: begin
				if (!slot_rdata[0] || (slot_q == CW'(1))) begin
					state_d = djs_pkg::ST_NEXT;
				end else begin
					state_d = djs_pkg::ST_PROBE_RD;
				end
			end
			djs_pkg::ST_NEXT: begin
				state_d = (round_q + 1'b1 == n_q) ? djs_pkg::ST_OUT : djs_pkg::ST_SEL;
			end
			djs_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = djs_pkg::ST_IDLE;
				end
			end
			default: state_d = djs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
			round_q <= '0;
			slot_q  <= '0;
			done_q  <= '0;
			sum_q   <= '0;
			found_q <= 1'b0;
		end else begin
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (in_acc) begin
				if (in_data.last_job) begin
					fill_q  <= '0;
					n_q     <= fill_q + CW'(fill_q != MAX_C);
					round_q <= '0;
					done_q  <= '0;
					sum_q   <= '0;
					found_q <= 1'b0;
				end else if (fill_q != MAX_C) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				djs_pkg::ST_MARK: begin
					slot_q  <= s_min;
					found_q <= 1'b0;
				end
				djs_pkg::ST_PROBE_EV: begin
					if (!slot_rdata[0]) begin
						done_q <= done_q + 1'b1;
						sum_q  <= sum_add[24] ? djs_pkg::SUM_MAX : sum_add[23:0];
					end else begin
						slot_q <= slot_m1;
					end
				end
				djs_pkg::ST_NEXT: begin
					round_q <= round_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= AW'(cnt_q - 1'b1);
			best_d_q   <= job_rdata[31:16];
			best_p_q   <= job_rdata[15:0];
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench for deadline_job_sequencer: directed job sets from a table, a store-full set, then random sets
// checks each schedule summary against an in-bench greedy scheduler; depends on djs_pkg
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NJOBS = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	djs_pkg::in_t in_data = '0;
	logic in_ready, out_valid;
	djs_pkg::out_t out_data;

	deadline_job_sequencer #(.MAX_JOBS(NJOBS)) u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [15:0] set_dl[NJOBS];
	logic [15:0] set_pr[NJOBS];
	int set_len = 0;
	djs_pkg::out_t summary_q[$];
	int errors = 0;
	int out_beats = 0;

	function automatic djs_pkg::out_t schedule_jobs();
		logic [15:0] od[NJOBS];
		logic [15:0] op[NJOBS];
		bit taken[NJOBS + 1];
		int k, s, done;
		logic [31:0] sum;
		djs_pkg::out_t r;
		done = 0;
		sum = 0;
		for (int i = 0; i <= NJOBS; i++) taken[i] = 0;
		for (int i = 0; i < set_len; i++) begin
			k = i;
			while (k > 0 && op[k - 1] < set_pr[i]) begin
				op[k] = op[k - 1];
				od[k] = od[k - 1];
				k--;
			end
			op[k] = set_pr[i];
			od[k] = set_dl[i];
		end
		for (int i = 0; i < set_len; i++) begin
			s = int'(od[i]);
			if (s > set_len) s = set_len;
			while (s >= 1) begin
				if (!taken[s]) begin
					taken[s] = 1;
					done++;
					sum += 32'(op[i]);
					if (sum > 32'(djs_pkg::SUM_MAX)) sum = 32'(djs_pkg::SUM_MAX);
					break;
				end
				s--;
			end
		end
		if (done > int'(djs_pkg::DONE_MAX)) done = int'(djs_pkg::DONE_MAX);
		r.jobs_done = done[8:0];
		r.total_profit = sum[23:0];
		return r;
	endfunction

	// absorb one job into the shadow set; queues the expected summary on last
	task automatic log_job(input djs_pkg::in_t j, input bit has_fixed,
			input djs_pkg::out_t fixed);
		djs_pkg::out_t e;
		if (set_len < NJOBS) begin
			set_dl[set_len] = j.deadline;
			set_pr[set_len] = j.profit;
			set_len++;
		end
		if (j.last_job) begin
			e = schedule_jobs();
			if (has_fixed && e != fixed) begin
				$display("%0t table row disagrees: table %h scheduler %h", $time, fixed, e);
				errors++;
			end
			summary_q.push_back(has_fixed ? fixed : e);
			set_len = 0;
		end
	endtask

	task automatic send_job(input djs_pkg::in_t j, input bit has_fixed,
			input djs_pkg::out_t fixed);
		int gap;
		gap = $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= j;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		log_job(j, has_fixed, fixed);
	endtask

	task automatic send_set(input int n, input int dmax, input int pmax);
		djs_pkg::in_t j;
		for (int i = 0; i < n; i++) begin
			j.deadline = 16'($urandom_range(0, dmax));
			j.profit = 16'($urandom_range(0, pmax));
			j.last_job = (i == n - 1);
			send_job(j, 0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			out_beats++;
			if (summary_q.size() == 0) begin
				$display("%0t unexpected beat: expected none actual %h", $time, out_data);
				errors++;
			end else begin
				if (out_data.jobs_done != summary_q[0].jobs_done) begin
					$display("%0t jobs_done expected %0d actual %0d", $time,
						summary_q[0].jobs_done, out_data.jobs_done);
					errors++;
				end
				if (out_data.total_profit != summary_q[0].total_profit) begin
					$display("%0t total_profit expected %0d actual %0d", $time,
						summary_q[0].total_profit, out_data.total_profit);
					errors++;
				end
				void'(summary_q.pop_front());
			end
		end
	end

	initial begin
		int stall;
		forever begin
			@(posedge clk);
			stall = $urandom_range(0, 17);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (out_valid && out_ready) begin
				out_ready <= 1'b0;
			end else if (!out_ready) begin
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	typedef struct {
		djs_pkg::in_t job;
		bit fixed;
		djs_pkg::out_t res;
	} row_t;

	row_t rows[$];

	function automatic row_t mk(input logic [15:0] d, input logic [15:0] p, input bit l,
			input bit f, input logic [8:0] n, input logic [23:0] s);
		row_t r;
		r.job.deadline = d;
		r.job.profit = p;
		r.job.last_job = l;
		r.fixed = f;
		r.res.jobs_done = n;
		r.res.total_profit = s;
		return r;
	endfunction

	initial begin
		int sent;
		djs_pkg::in_t j;
		rows.push_back(mk(16'd0, 16'hFFFF, 1, 1, 9'd0, 24'd0));
		rows.push_back(mk(16'd1, 16'hFFFF, 1, 1, 9'd1, 24'hFFFF));
		rows.push_back(mk(16'hFFFF, 16'd0, 1, 1, 9'd1, 24'd0));
		rows.push_back(mk(16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
		rows.push_back(mk(16'hFFFF, 16'hFFFF, 1, 1, 9'd2, 24'h1FFFE));
		rows.push_back(mk(16'd1, 16'd5, 0, 0, 0, 0));
		rows.push_back(mk(16'd1, 16'd9, 0, 0, 0, 0));
		rows.push_back(mk(16'd1, 16'd7, 1, 1, 9'd1, 24'd9));
		rows.push_back(mk(16'd2, 16'd100, 0, 0, 0, 0));
		rows.push_back(mk(16'd1, 16'd19, 0, 0, 0, 0));
		rows.push_back(mk(16'd2, 16'd27, 0, 0, 0, 0));
		rows.push_back(mk(16'd1, 16'd25, 0, 0, 0, 0));
		rows.push_back(mk(16'd3, 16'd15, 1, 0, 0, 0));
		rows.push_back(mk(16'd3, 16'd4, 0, 0, 0, 0));
		rows.push_back(mk(16'd3, 16'd4, 0, 0, 0, 0));
		rows.push_back(mk(16'd0, 16'd8, 0, 0, 0, 0));
		rows.push_back(mk(16'd3, 16'd4, 1, 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_job(rows[i].job, rows[i].fixed, rows[i].res);

		// store full: 256 jobs, then dropped extras, closed by a dropped last job
		for (int i = 0; i < NJOBS + 3; i++) begin
			j.deadline = (i % 3 == 0) ? 16'hFFFF : 16'($urandom_range(0, 300));
			j.profit = (i % 5 == 0) ? 16'hFFFF : 16'($urandom);
			j.last_job = (i == NJOBS + 2);
			send_job(j, 0, '0);
		end

		// hold off until every summary has come back
		in_valid <= 1'b0;
		@(posedge clk);
		while (summary_q.size() != 0) @(posedge clk);

		sent = 0;
		while (sent < 1620) begin
			int n;
			if ($urandom_range(0, 40) == 0) n = $urandom_range(100, NJOBS + 2);
			else n = $urandom_range(1, 12);
			case ($urandom_range(0, 3))
				0: send_set(n, 65535, 65535);
				1: send_set(n, n + 1, 65535);
				2: send_set(n, n, 3);
				default: send_set(n, 3, $urandom_range(0, 1) ? 65535 : 40);
			endcase
			sent += n;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (summary_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#1200ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/djs_pkg.sv
rtl/djs_ram.sv
rtl/deadline_job_sequencer.sv
tb/tb_top.sv
